FILE: sv/glw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package glw_pkg;

    localparam int unsigned TIME_W = 64;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] DEFAULT_SILENCE_LIMIT = 32'd180000;

    // Widths of the stream payloads; the data widths are padded to whole bytes.
    localparam int unsigned IN_DATA_W  = 232;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 200;

    typedef enum logic [1:0] {
        REQ_POLL    = 2'd0,
        REQ_REPLY   = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        VERDICT_NOT_CHECKED  = 3'd0,
        VERDICT_HEALTHY      = 3'd1,
        VERDICT_NEVER_BONDED = 3'd2,
        VERDICT_PEER_FRESH   = 3'd3,
        VERDICT_ABORT        = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] now_ms;
        logic [WORD_W-1:0] gateway_addr;
        logic              ap_fallback;
        logic [TIME_W-1:0] peer_last_reply_ms;
        logic [WORD_W-1:0] session_tag;
        logic [WORD_W-1:0] round_trip_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]        verdict;
        logic              retargeted;
        logic              armed_now;
        logic [WORD_W-1:0] generation_now;
        logic [WORD_W-1:0] reply_total;
        logic [WORD_W-1:0] loss_total;
        logic [WORD_W-1:0] last_rtt_ms;
        logic [WORD_W-1:0] peak_rtt_ms;
        logic [WORD_W-1:0] gateway_silent_ms;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/glw_core.sv
`timescale 1ns / 1ps
`default_nettype none

module glw_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [31:0]      cfg_wdata,
    input  wire logic             fire,
    input  wire glw_pkg::item_t   item,
    output glw_pkg::result_t      result
);
    import glw_pkg::*;

    logic [WORD_W-1:0] timeout_reg;
    logic [TIME_W-1:0] last_ok_reg, last_ok_next;
    logic [WORD_W-1:0] reply_reg, reply_next;
    logic [WORD_W-1:0] loss_reg, loss_next;
    logic [WORD_W-1:0] rtt_reg, rtt_next;
    logic [WORD_W-1:0] max_rtt_reg, max_rtt_next;
    logic              armed_reg, armed_next;
    logic [WORD_W-1:0] gen_reg, gen_next;
    logic [WORD_W-1:0] target_reg, target_next;

    logic              tag_match;
    logic              moved;
    logic              stamp;
    logic [TIME_W:0]   ok_diff;
    logic [TIME_W:0]   peer_diff;
    logic              now_ge_ok;
    logic [TIME_W-1:0] silence;
    verdict_t          verdict;
    logic [WORD_W-1:0] silent;

    assign tag_match = (item.session_tag == gen_reg);

    // One subtract serves both the poll check and the silence output; the
    // borrow bit tells whether time has run backwards.
    assign ok_diff   = {1'b0, item.now_ms} - {1'b0, last_ok_reg};
    assign peer_diff = {1'b0, item.now_ms} - {1'b0, item.peer_last_reply_ms};
    assign now_ge_ok = ~ok_diff[TIME_W];
    assign silence   = now_ge_ok ? ok_diff[TIME_W-1:0] : '0;

    always_comb
    begin
        last_ok_next = last_ok_reg;
        reply_next   = reply_reg;
        loss_next    = loss_reg;
        rtt_next     = rtt_reg;
        max_rtt_next = max_rtt_reg;
        armed_next   = armed_reg;
        gen_next     = gen_reg;
        target_next  = target_reg;
        moved        = 1'b0;
        stamp        = 1'b0;
        verdict      = VERDICT_NOT_CHECKED;
        unique case (item.req_type)
            REQ_POLL:
            begin
                moved = (item.gateway_addr != target_reg);
                if (moved)
                begin
                    target_next = item.gateway_addr;
                    armed_next  = 1'b0;
                    if (item.gateway_addr != '0)
                    begin
                        last_ok_next = item.now_ms;
                        gen_next     = gen_reg + 32'd1;
                        stamp        = 1'b1;
                    end
                end
                // After a retarget the block is disarmed, so the old stamp
                // is only ever compared when nothing moved.
                if (target_next == '0 || !armed_next || item.ap_fallback)
                    verdict = VERDICT_NOT_CHECKED;
                else if (!(silence > {{(TIME_W-WORD_W){1'b0}}, timeout_reg}))
                    verdict = VERDICT_HEALTHY;
                else if (item.peer_last_reply_ms == '0)
                    verdict = VERDICT_NEVER_BONDED;
                else if (!peer_diff[TIME_W] &&
                         peer_diff[TIME_W-1:0] < {{(TIME_W-WORD_W){1'b0}}, timeout_reg})
                    verdict = VERDICT_PEER_FRESH;
                else
                    verdict = VERDICT_ABORT;
            end
            REQ_REPLY:
            begin
                if (tag_match)
                begin
                    last_ok_next = item.now_ms;
                    reply_next   = reply_reg + 32'd1;
                    armed_next   = 1'b1;
                    rtt_next     = item.round_trip_ms;
                    stamp        = 1'b1;
                    if (item.round_trip_ms > max_rtt_reg)
                        max_rtt_next = item.round_trip_ms;
                end
            end
            REQ_TIMEOUT:
            begin
                if (tag_match)
                    loss_next = loss_reg + 32'd1;
            end
            default:
            begin
            end
        endcase
    end

    // A fresh stamp equals now, so the silence is zero in that case.
    always_comb
    begin
        if (reply_next == '0 || stamp || !now_ge_ok)
            silent = '0;
        else
            silent = ok_diff[WORD_W-1:0];
    end

    always_comb
    begin
        result.verdict           = verdict;
        result.retargeted        = moved;
        result.armed_now         = armed_next;
        result.generation_now    = gen_next;
        result.reply_total       = reply_next;
        result.loss_total        = loss_next;
        result.last_rtt_ms       = rtt_next;
        result.peak_rtt_ms       = max_rtt_next;
        result.gateway_silent_ms = silent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= DEFAULT_SILENCE_LIMIT;
            last_ok_reg <= '0;
            reply_reg   <= '0;
            loss_reg    <= '0;
            rtt_reg     <= '0;
            max_rtt_reg <= '0;
            armed_reg   <= 1'b0;
            gen_reg     <= '0;
            target_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (fire)
            begin
                last_ok_reg <= last_ok_next;
                reply_reg   <= reply_next;
                loss_reg    <= loss_next;
                rtt_reg     <= rtt_next;
                max_rtt_reg <= max_rtt_next;
                armed_reg   <= armed_next;
                gen_reg     <= gen_next;
                target_reg  <= target_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/gateway_liveness_watchdog.sv
`timescale 1ns / 1ps
`default_nettype none

// Gateway liveness watchdog. Each input beat (poll tick, probe reply or probe
// timeout) yields exactly one result beat. An item is registered on entry,
// evaluated against the watchdog state while it waits in the input register
// and written to the result register, so one item is taken every cycle while
// the output is not stalled; the rate is set by the state update, whose
// longest path is a 64-bit time subtract followed by the compare against
// the silence limit. The result register and the input register together let
// one new beat be taken while a finished result still waits downstream.
// The silence limit is written through cfg_we/cfg_wdata; the user must write
// it only while the block idles, as the block itself does not enforce this.
module gateway_liveness_watchdog (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [31:0]                      cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // now_ms[63:0], gateway_addr[95:64], ap_fallback[96],
    // peer_last_reply_ms[160:97], session_tag[192:161], round_trip_ms[224:193]
    input  wire logic [glw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  wire logic [glw_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // verdict[2:0], retargeted[3], armed_now[4], generation_now[36:5],
    // reply_total[68:37], loss_total[100:69], last_rtt_ms[132:101],
    // peak_rtt_ms[164:133], gateway_silent_ms[196:165]
    output logic [glw_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import glw_pkg::*;

    item_t   in_item;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_free;
    logic    fire;

    always_comb
    begin
        in_item.req_type           = s_axis_tuser;
        in_item.now_ms             = s_axis_tdata[63:0];
        in_item.gateway_addr       = s_axis_tdata[95:64];
        in_item.ap_fallback        = s_axis_tdata[96];
        in_item.peer_last_reply_ms = s_axis_tdata[160:97];
        in_item.session_tag        = s_axis_tdata[192:161];
        in_item.round_trip_ms      = s_axis_tdata[224:193];
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;

    glw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_free)
                out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            item_reg <= in_item;
        if (fire)
            result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        m_axis_tdata          = '0;
        m_axis_tdata[2:0]     = result_reg.verdict;
        m_axis_tdata[3]       = result_reg.retargeted;
        m_axis_tdata[4]       = result_reg.armed_now;
        m_axis_tdata[36:5]    = result_reg.generation_now;
        m_axis_tdata[68:37]   = result_reg.reply_total;
        m_axis_tdata[100:69]  = result_reg.loss_total;
        m_axis_tdata[132:101] = result_reg.last_rtt_ms;
        m_axis_tdata[164:133] = result_reg.peak_rtt_ms;
        m_axis_tdata[196:165] = result_reg.gateway_silent_ms;
    end

endmodule

`default_nettype wire

FILE: verif/tb_gateway_liveness_watchdog.sv
`timescale 1ns / 1ps

module tb_gateway_liveness_watchdog;

    import glw_pkg::*;

    // The request code that the block must treat as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned EVENTS_PER_SETTING = 200;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [31:0]           cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    gateway_liveness_watchdog dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog state as the block should hold it.
    logic [63:0] wd_last_ok  = '0;
    logic [31:0] wd_replies  = '0;
    logic [31:0] wd_losses   = '0;
    logic [31:0] wd_rtt_last = '0;
    logic [31:0] wd_rtt_peak = '0;
    logic        wd_armed    = 1'b0;
    logic [31:0] wd_gen      = '0;
    logic [31:0] wd_target   = '0;
    logic [31:0] wd_limit    = DEFAULT_SILENCE_LIMIT;

    // Shadow of the few state bits the stimulus needs to stay well formed.
    logic [63:0] plan_now     = '0;
    logic [63:0] plan_last_ok = '0;
    logic [31:0] plan_gen     = '0;
    logic [31:0] plan_target  = '0;
    logic [31:0] plan_limit   = DEFAULT_SILENCE_LIMIT;

    item_t   probe_events [$];
    result_t predicted_status [$];

    item_t       offered;
    result_t     seen;
    result_t     want;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    int unsigned sender_gap_max = 9;
    int unsigned receiver_stall_max = 9;
    logic        hold_results = 1'b0;
    int unsigned accepted_count = 0;
    int unsigned fail_count = 0;
    int unsigned retarget_count = 0;
    int unsigned verdict_tally [8] = '{default: 0};
    int unsigned cycle_count = 0;

    function automatic result_t advance_watchdog(item_t it);
        result_t     r;
        logic [63:0] quiet;
        logic [63:0] since_reply;
        r = '0;
        case (it.req_type)
            REQ_POLL:
            begin
                r.retargeted = (it.gateway_addr != wd_target);
                if (r.retargeted)
                begin
                    wd_target = it.gateway_addr;
                    wd_armed  = 1'b0;
                    if (it.gateway_addr != 32'd0)
                    begin
                        wd_last_ok = it.now_ms;
                        wd_gen     = wd_gen + 32'd1;
                    end
                end
                if (wd_target == 32'd0 || !wd_armed || it.ap_fallback)
                    r.verdict = VERDICT_NOT_CHECKED;
                else
                begin
                    quiet = (it.now_ms >= wd_last_ok) ? it.now_ms - wd_last_ok : 64'd0;
                    if (quiet <= {32'd0, wd_limit})
                        r.verdict = VERDICT_HEALTHY;
                    else if (it.peer_last_reply_ms == 64'd0)
                        r.verdict = VERDICT_NEVER_BONDED;
                    else if (it.now_ms >= it.peer_last_reply_ms &&
                             it.now_ms - it.peer_last_reply_ms < {32'd0, wd_limit})
                        r.verdict = VERDICT_PEER_FRESH;
                    else
                        r.verdict = VERDICT_ABORT;
                end
            end
            REQ_REPLY:
            begin
                if (it.session_tag == wd_gen)
                begin
                    wd_last_ok  = it.now_ms;
                    wd_replies  = wd_replies + 32'd1;
                    wd_armed    = 1'b1;
                    wd_rtt_last = it.round_trip_ms;
                    if (it.round_trip_ms > wd_rtt_peak)
                        wd_rtt_peak = it.round_trip_ms;
                end
            end
            REQ_TIMEOUT:
            begin
                if (it.session_tag == wd_gen)
                    wd_losses = wd_losses + 32'd1;
            end
            default:
            begin
                // The spare request code leaves every piece of state alone.
            end
        endcase
        since_reply = it.now_ms - wd_last_ok;
        if (wd_replies != 32'd0 && it.now_ms > wd_last_ok)
            r.gateway_silent_ms = since_reply[31:0];
        r.armed_now      = wd_armed;
        r.generation_now = wd_gen;
        r.reply_total    = wd_replies;
        r.loss_total     = wd_losses;
        r.last_rtt_ms    = wd_rtt_last;
        r.peak_rtt_ms    = wd_rtt_peak;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val,
                                        logic [31:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    // Sender: one beat in flight, a random pause after each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_status.push_back(advance_watchdog(offered));
                accepted_count <= accepted_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (probe_events.size() != 0)
                begin
                    offered = probe_events.pop_front();
                    s_axis_tdata  <= {7'd0, offered.round_trip_ms, offered.session_tag,
                                      offered.peer_last_reply_ms, offered.ap_fallback,
                                      offered.gateway_addr, offered.now_ms};
                    s_axis_tuser  <= offered.req_type;
                    s_axis_tvalid <= 1'b1;
                    gap_left      <= $urandom_range(0, sender_gap_max);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result beat, then stalls for a random count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.verdict           = m_axis_tdata[2:0];
                seen.retargeted        = m_axis_tdata[3];
                seen.armed_now         = m_axis_tdata[4];
                seen.generation_now    = m_axis_tdata[36:5];
                seen.reply_total       = m_axis_tdata[68:37];
                seen.loss_total        = m_axis_tdata[100:69];
                seen.last_rtt_ms       = m_axis_tdata[132:101];
                seen.peak_rtt_ms       = m_axis_tdata[164:133];
                seen.gateway_silent_ms = m_axis_tdata[196:165];
                verdict_tally[seen.verdict] += 1;
                if (seen.retargeted)
                    retarget_count++;
                if (predicted_status.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %0h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(seen.verdict));
                    check_field("retargeted", 32'(want.retargeted), 32'(seen.retargeted));
                    check_field("armed_now", 32'(want.armed_now), 32'(seen.armed_now));
                    check_field("generation_now", want.generation_now, seen.generation_now);
                    check_field("reply_total", want.reply_total, seen.reply_total);
                    check_field("loss_total", want.loss_total, seen.loss_total);
                    check_field("last_rtt_ms", want.last_rtt_ms, seen.last_rtt_ms);
                    check_field("peak_rtt_ms", want.peak_rtt_ms, seen.peak_rtt_ms);
                    check_field("gateway_silent_ms", want.gateway_silent_ms,
                                seen.gateway_silent_ms);
                end
                stall_draw = $urandom_range(0, receiver_stall_max);
                stall_left    <= stall_draw;
                m_axis_tready <= (stall_draw == 0) && !hold_results;
            end
            else if (stall_left != 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= (stall_left == 1) && !hold_results;
            end
            else
                m_axis_tready <= !hold_results;
        end
    end

    // Long back-pressure in the middle of an unthrottled stretch, so that the
    // block fills up and has to refuse input.
    initial
    begin
        wait (accepted_count >= 300);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (300) @(posedge clk);
        hold_results <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_status.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic plan_event(logic [1:0] kind, logic [63:0] now, logic [31:0] gw,
                              logic ap, logic [63:0] peer, logic [31:0] tag,
                              logic [31:0] rtt);
        item_t it;
        it.req_type           = kind;
        it.now_ms             = now;
        it.gateway_addr       = gw;
        it.ap_fallback        = ap;
        it.peer_last_reply_ms = peer;
        it.session_tag        = tag;
        it.round_trip_ms      = rtt;
        probe_events.push_back(it);
        plan_now = now;
        if (kind == REQ_POLL && gw != plan_target)
        begin
            plan_target = gw;
            if (gw != 32'd0)
            begin
                plan_gen     = plan_gen + 32'd1;
                plan_last_ok = now;
            end
        end
        if (kind == REQ_REPLY && tag == plan_gen)
            plan_last_ok = now;
    endtask

    task automatic queue_random_event();
        logic [63:0] span;
        logic [63:0] now;
        logic [63:0] peer;
        logic [31:0] gw;
        logic [31:0] tag;
        logic [31:0] rtt;
        logic [1:0]  kind;
        int unsigned pick;
        span = {32'd0, plan_limit};
        pick = $urandom_range(0, 99);
        if (pick < 40)
            kind = REQ_POLL;
        else if (pick < 75)
            kind = REQ_REPLY;
        else if (pick < 97)
            kind = REQ_TIMEOUT;
        else
            kind = REQ_UNUSED;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: now = plan_now + $urandom_range(0, 2000);
            4: now = plan_now + (span >> 1);
            // Right on the silence limit or one past it.
            5: now = plan_last_ok + span + $urandom_range(0, 1);
            6: now = plan_now + span + $urandom_range(0, 100000);
            7: now = plan_now + {32'd0, $urandom};
            8: now = plan_now - $urandom_range(0, 5000);
            default: now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : plan_now;
        endcase
        case ($urandom_range(0, 7))
            0: peer = 64'd0;
            1: peer = now - span + 64'd1;
            2: peer = now - span;
            3: peer = now - $urandom_range(0, plan_limit);
            4: peer = now + $urandom_range(1, 1000);
            5: peer = {$urandom, $urandom};
            default: peer = now - $urandom_range(0, 1000);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 85)
            gw = plan_target;
        else if (pick < 95)
            gw = $urandom;
        else
            gw = 32'd0;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            tag = plan_gen;
        else if (pick < 90)
            tag = $urandom_range(0, 1) ? plan_gen + 32'd1 : plan_gen - 32'd1;
        else
            tag = $urandom;
        rtt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 500);
        plan_event(kind, now, gw, $urandom_range(0, 4) == 0, peer, tag, rtt);
    endtask

    task automatic wait_drained();
        while (probe_events.size() != 0 || s_axis_tvalid || predicted_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wd_limit   = value;
        plan_limit = value;
    endtask

    initial
    begin
        logic [31:0] settings [7];
        logic [63:0] t0;
        logic [63:0] t_max;
        settings = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd5000, 32'd180000, 32'd0, 32'd3};
        settings[5] = $urandom_range(1, 1000000);
        t_max = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default limit of 180000 ms. Tag 0 counts before the first retarget.
        plan_event(REQ_REPLY, 64'd1000, 32'd0, 1'b0, 64'd0, 32'd0, 32'd5);
        plan_event(REQ_POLL, 64'd2000, 32'd0, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_TIMEOUT, 64'd2100, 32'd0, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_UNUSED, 64'd2200, '1, 1'b1, '1, 32'd0, '1);
        plan_event(REQ_POLL, 64'd3000, 32'hC0A8_0001, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_REPLY, 64'd3050, 32'd0, 1'b0, 64'd0, 32'd0, 32'd9);
        plan_event(REQ_TIMEOUT, 64'd3060, 32'd0, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_REPLY, 64'd3100, 32'd0, 1'b0, 64'd0, 32'd1, '1);
        // Silence exactly at the limit is still healthy; one more ms is not.
        t0 = 64'd3100 + 64'd180000;
        plan_event(REQ_POLL, t0, 32'hC0A8_0001, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_POLL, t0 + 1, 32'hC0A8_0001, 1'b1, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_POLL, t0 + 1, 32'hC0A8_0001, 1'b0, 64'd0, 32'd0, 32'd0);
        t0 = 64'd3100 + 64'd200000;
        plan_event(REQ_POLL, t0, 32'hC0A8_0001, 1'b0, t0 - 64'd179999, 32'd0, 32'd0);
        plan_event(REQ_POLL, t0, 32'hC0A8_0001, 1'b0, t0 - 64'd180000, 32'd0, 32'd0);
        plan_event(REQ_POLL, t0, 32'hC0A8_0001, 1'b0, t0 + 64'd5, 32'd0, 32'd0);
        // Time running backwards reads as no silence at all.
        plan_event(REQ_POLL, 64'd10, 32'hC0A8_0001, 1'b0, 64'd1, 32'd0, 32'd0);
        plan_event(REQ_REPLY, t_max, 32'd0, 1'b0, 64'd0, 32'd1, 32'd7);
        plan_event(REQ_TIMEOUT, t_max, 32'd0, 1'b0, 64'd0, 32'd1, 32'd0);
        plan_event(REQ_POLL, t_max, '1, 1'b0, t_max, 32'd0, 32'd0);
        plan_event(REQ_POLL, t_max, 32'd0, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_REPLY, t_max, 32'd0, 1'b0, 64'd0, 32'd2, 32'd0);
        plan_event(REQ_POLL, t_max, 32'd0, 1'b0, 64'd0, 32'd0, 32'd0);
        plan_event(REQ_REPLY, t_max, 32'd0, 1'b0, 64'd0, '1, '1);
        wait_drained();

        for (int i = 0; i < 7; i++)
        begin
            write_timeout(settings[i]);
            case (i % 3)
                0:
                begin
                    sender_gap_max     <= 9;
                    receiver_stall_max <= 9;
                end
                1:
                begin
                    sender_gap_max     <= 0;
                    receiver_stall_max <= 0;
                end
                default:
                begin
                    sender_gap_max     <= 0;
                    receiver_stall_max <= 9;
                end
            endcase
            @(posedge clk);
            repeat (EVENTS_PER_SETTING) queue_random_event();
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Ran %0d events under 8 timeout settings, %0d of them retargets.",
                 accepted_count, retarget_count);
        $display("Verdicts: unchecked %0d, healthy %0d, never bonded %0d, fresh %0d, abort %0d.",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
